@@ rtl/rpn_stack_calculator_defines.svh @@
// Assertion macros for the RPN calculator.
`ifndef RPN_STACK_CALCULATOR_DEFINES_SVH
`define RPN_STACK_CALCULATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RPN_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RPN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/rpn_pkg.sv @@
package rpn_pkg;

	localparam int MAX_RESULTS = 16;

	localparam logic [2:0] OP_PUSH = 3'd0;
	localparam logic [2:0] OP_POP  = 3'd1;
	localparam logic [2:0] OP_LIST = 3'd2;
	localparam logic [2:0] OP_ADD  = 3'd3;
	localparam logic [2:0] OP_MUL  = 3'd4;
	localparam logic [2:0] OP_DIV  = 3'd5;
	localparam logic [2:0] OP_SUB  = 3'd6;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_POPPED  = 3'd1;
	localparam logic [2:0] ST_LIST    = 3'd2;
	localparam logic [2:0] ST_EMPTY   = 3'd3;
	localparam logic [2:0] ST_FEW     = 3'd4;
	localparam logic [2:0] ST_FULL    = 3'd5;
	localparam logic [2:0] ST_DIVZERO = 3'd6;

	typedef enum logic [1:0] {RS_TOP, RS_SECOND, RS_PTR} rd_sel_t;
	typedef enum logic [1:0] {RES_ADD, RES_SUB, RES_MUL, RES_DIV} res_sel_t;
	typedef enum logic [1:0] {DS_ZERO, DS_RD, DS_RES} data_sel_t;

	typedef struct packed {
		logic       latch;
		logic       rd_en;
		rd_sel_t    rd_sel;
		logic       ld_b;
		logic       ld_a;
		logic       ptr_init;
		logic       ptr_inc;
		logic       mul_start;
		logic       div_start;
		logic       push_wr;
		logic       arith_wr;
		res_sel_t   res_sel;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       emit;
		logic [2:0] emit_status;
		data_sel_t  data_sel;
		logic       emit_last;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       empty;
		logic       few;
		logic       full;
		logic       b_zero;
		logic       list_last;
		logic       mul_done;
		logic       div_done;
	} sts_t;

endpackage

@@ rtl/rpn_mul.sv @@
// 64x64 multiply, low 64 bits, from three 32x32 partial products.
module rpn_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] product,
	output logic        done
);

	logic        run_q;
	logic [1:0]  ph_q;
	logic        done_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic [31:0] x;
	logic [31:0] y;

	always_comb begin
		case (ph_q)
			2'd0: begin
				x = a[31:0];
				y = b[31:0];
			end
			2'd1: begin
				x = a[63:32];
				y = b[31:0];
			end
			default: begin
				x = a[31:0];
				y = b[63:32];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			ph_q   <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (ph_q == 2'd3);
			if (start) begin
				run_q <= 1'b1;
				ph_q  <= 2'd0;
			end else if (run_q) begin
				ph_q <= ph_q + 2'd1;
				if (ph_q == 2'd3)
					run_q <= 1'b0;
			end
		end
	end

	// product of phase n lands in acc during phase n+1
	always_ff @(posedge clk) begin
		if (run_q) begin
			prod_q <= x * y;
			case (ph_q)
				2'd0:    acc_q <= acc_q;
				2'd1:    acc_q <= prod_q;
				default: acc_q <= acc_q + {prod_q[31:0], 32'd0};
			endcase
		end
	end

	assign product = acc_q;
	assign done    = done_q;

endmodule

@@ rtl/rpn_div.sv @@
// Signed 64-bit divide, truncating; restoring, one quotient bit per cycle.
module rpn_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic [63:0] quotient,
	output logic        done
);

	logic        run_q;
	logic        fix_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic [63:0] den_q;
	logic [63:0] quo_q;
	logic [64:0] rem_q;
	logic [64:0] rem_sh;
	logic [64:0] diff;
	logic        take;

	assign rem_sh = {rem_q[63:0], quo_q[63]};
	assign diff   = rem_sh - {1'b0, den_q};
	assign take   = !diff[64];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= fix_q;
			fix_q  <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q <= 1'b0;
					fix_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[63] ^ divisor[63];
			den_q <= divisor[63] ? (64'd0 - divisor) : divisor;
			quo_q <= dividend[63] ? (64'd0 - dividend) : dividend;
			rem_q <= 65'd0;
		end else if (run_q) begin
			rem_q <= take ? diff : rem_sh;
			quo_q <= {quo_q[62:0], take};
		end else if (fix_q) begin
			quo_q <= neg_q ? (64'd0 - quo_q) : quo_q;
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

@@ rtl/rpn_dpath.sv @@
// Stack memory, count, operand registers, arithmetic units, result register.
module rpn_dpath #(
	parameter int STACK_DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [2:0]     in_op,
	input  logic [63:0]    in_value,
	input  rpn_pkg::cmd_t  cmd,
	output rpn_pkg::sts_t  sts,
	output logic           strobe,
	output logic [2:0]     status,
	output logic [63:0]    data,
	output logic           last
);

	localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [63:0]   mem [STACK_DEPTH];
	logic [2:0]    op_q;
	logic [63:0]   val_q;
	logic [63:0]   a_q;
	logic [63:0]   b_q;
	logic [63:0]   rd_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] ptr_q;
	logic          strobe_q;
	logic [2:0]    status_q;
	logic [63:0]   data_q;
	logic          last_q;

	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_m2;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] wr_addr;
	logic [63:0]   wr_data;
	logic [63:0]   res;
	logic [63:0]   mul_res;
	logic [63:0]   div_res;
	logic          mul_done;
	logic          div_done;

	assign cnt_m1 = cnt_q - CW'(1);
	assign cnt_m2 = cnt_q - CW'(2);

	always_comb begin
		case (cmd.rd_sel)
			rpn_pkg::RS_SECOND: rd_addr = cnt_m2[IW-1:0];
			rpn_pkg::RS_PTR:    rd_addr = ptr_q[IW-1:0];
			default:            rd_addr = cnt_m1[IW-1:0];
		endcase
	end

	always_comb begin
		case (cmd.res_sel)
			rpn_pkg::RES_SUB: res = a_q - b_q;
			rpn_pkg::RES_MUL: res = mul_res;
			rpn_pkg::RES_DIV: res = div_res;
			default:          res = a_q + b_q;
		endcase
	end

	assign wr_addr = cmd.push_wr ? cnt_q[IW-1:0] : cnt_m2[IW-1:0];
	assign wr_data = cmd.push_wr ? val_q : res;

	always_ff @(posedge clk) begin
		if (cmd.push_wr || cmd.arith_wr)
			mem[wr_addr] <= wr_data;
		if (cmd.rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= in_op;
			val_q <= in_value;
		end
		if (cmd.ld_b)
			b_q <= rd_q;
		if (cmd.ld_a)
			a_q <= rd_q;
		if (cmd.ptr_init) begin
			if (32'(cnt_q) > 32'(rpn_pkg::MAX_RESULTS))
				ptr_q <= cnt_q - CW'(rpn_pkg::MAX_RESULTS);
			else
				ptr_q <= '0;
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + CW'(1);
		end
		if (cmd.emit) begin
			status_q <= cmd.emit_status;
			last_q   <= cmd.emit_last;
			case (cmd.data_sel)
				rpn_pkg::DS_RD:  data_q <= rd_q;
				rpn_pkg::DS_RES: data_q <= res;
				default:         data_q <= 64'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
			if (cmd.cnt_inc)
				cnt_q <= cnt_q + CW'(1);
			else if (cmd.cnt_dec)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	rpn_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_start),
		.a       (a_q),
		.b       (b_q),
		.product (mul_res),
		.done    (mul_done)
	);

	rpn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (a_q),
		.divisor  (b_q),
		.quotient (div_res),
		.done     (div_done)
	);

	always_comb begin
		sts.op        = op_q;
		sts.empty     = (cnt_q == '0);
		sts.few       = (cnt_q < CW'(2));
		sts.full      = (cnt_q == CW'(STACK_DEPTH));
		sts.b_zero    = (b_q == 64'd0);
		sts.list_last = (ptr_q == cnt_q);
		sts.mul_done  = mul_done;
		sts.div_done  = div_done;
	end

	assign strobe = strobe_q;
	assign status = status_q;
	assign data   = data_q;
	assign last   = last_q;

endmodule

@@ rtl/rpn_ctrl.sv @@
// Sequencer: decodes the latched op and steps the datapath.
module rpn_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rpn_pkg::sts_t sts,
	output rpn_pkg::cmd_t cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC  = 4'd1;
	localparam logic [3:0] S_POUT = 4'd2;
	localparam logic [3:0] S_LRD  = 4'd3;
	localparam logic [3:0] S_LOUT = 4'd4;
	localparam logic [3:0] S_RDA  = 4'd5;
	localparam logic [3:0] S_OPS  = 4'd6;
	localparam logic [3:0] S_EXEC = 4'd7;
	localparam logic [3:0] S_MULW = 4'd8;
	localparam logic [3:0] S_DIVW = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_DEC;
				end
			end
			S_DEC: begin
				state_d = S_IDLE;
				unique case (sts.op) inside
					rpn_pkg::OP_PUSH: begin
						cmd.emit      = 1'b1;
						cmd.emit_last = 1'b1;
						cmd.data_sel  = rpn_pkg::DS_ZERO;
						if (sts.full) begin
							cmd.emit_status = rpn_pkg::ST_FULL;
						end else begin
							cmd.emit_status = rpn_pkg::ST_OK;
							cmd.push_wr     = 1'b1;
							cmd.cnt_inc     = 1'b1;
						end
					end
					rpn_pkg::OP_POP: begin
						if (sts.empty) begin
							cmd.emit        = 1'b1;
							cmd.emit_last   = 1'b1;
							cmd.emit_status = rpn_pkg::ST_EMPTY;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = rpn_pkg::RS_TOP;
							state_d    = S_POUT;
						end
					end
					rpn_pkg::OP_LIST: begin
						if (sts.empty) begin
							cmd.emit        = 1'b1;
							cmd.emit_last   = 1'b1;
							cmd.emit_status = rpn_pkg::ST_EMPTY;
						end else begin
							cmd.ptr_init = 1'b1;
							state_d      = S_LRD;
						end
					end
					rpn_pkg::OP_ADD, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV, rpn_pkg::OP_SUB: begin
						if (sts.few) begin
							cmd.emit        = 1'b1;
							cmd.emit_last   = 1'b1;
							cmd.emit_status = rpn_pkg::ST_FEW;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = rpn_pkg::RS_TOP;
							state_d    = S_RDA;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_POUT: begin
				cmd.emit        = 1'b1;
				cmd.emit_last   = 1'b1;
				cmd.emit_status = rpn_pkg::ST_POPPED;
				cmd.data_sel    = rpn_pkg::DS_RD;
				cmd.cnt_dec     = 1'b1;
				state_d         = S_IDLE;
			end
			S_LRD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = rpn_pkg::RS_PTR;
				cmd.ptr_inc = 1'b1;
				state_d     = S_LOUT;
			end
			S_LOUT: begin
				cmd.emit        = 1'b1;
				cmd.emit_status = rpn_pkg::ST_LIST;
				cmd.data_sel    = rpn_pkg::DS_RD;
				cmd.emit_last   = sts.list_last;
				state_d         = sts.list_last ? S_IDLE : S_LRD;
			end
			S_RDA: begin
				cmd.ld_b   = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = rpn_pkg::RS_SECOND;
				state_d    = S_OPS;
			end
			S_OPS: begin
				cmd.ld_a = 1'b1;
				state_d  = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_IDLE;
				unique case (sts.op) inside
					rpn_pkg::OP_ADD, rpn_pkg::OP_SUB: begin
						cmd.res_sel     = (sts.op == rpn_pkg::OP_SUB) ?
							rpn_pkg::RES_SUB : rpn_pkg::RES_ADD;
						cmd.arith_wr    = 1'b1;
						cmd.cnt_dec     = 1'b1;
						cmd.emit        = 1'b1;
						cmd.emit_last   = 1'b1;
						cmd.emit_status = rpn_pkg::ST_OK;
						cmd.data_sel    = rpn_pkg::DS_RES;
					end
					rpn_pkg::OP_MUL: begin
						cmd.mul_start = 1'b1;
						state_d       = S_MULW;
					end
					rpn_pkg::OP_DIV: begin
						if (sts.b_zero) begin
							cmd.emit        = 1'b1;
							cmd.emit_last   = 1'b1;
							cmd.emit_status = rpn_pkg::ST_DIVZERO;
						end else begin
							cmd.div_start = 1'b1;
							state_d       = S_DIVW;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_MULW: begin
				cmd.res_sel = rpn_pkg::RES_MUL;
				if (sts.mul_done) begin
					cmd.arith_wr    = 1'b1;
					cmd.cnt_dec     = 1'b1;
					cmd.emit        = 1'b1;
					cmd.emit_last   = 1'b1;
					cmd.emit_status = rpn_pkg::ST_OK;
					cmd.data_sel    = rpn_pkg::DS_RES;
					state_d         = S_IDLE;
				end
			end
			S_DIVW: begin
				cmd.res_sel = rpn_pkg::RES_DIV;
				if (sts.div_done) begin
					cmd.arith_wr    = 1'b1;
					cmd.cnt_dec     = 1'b1;
					cmd.emit        = 1'b1;
					cmd.emit_last   = 1'b1;
					cmd.emit_status = rpn_pkg::ST_OK;
					cmd.data_sel    = rpn_pkg::DS_RES;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ rtl/rpn_stack_calculator.sv @@
// RPN stack calculator: a bounded stack of signed 64-bit numbers.
// Input: drive op and value with start; the item is taken at the clock edge
// where start is high and busy is low. busy stays high until the item is done.
// Output: every result shows on status/data/last for exactly one cycle with
// strobe high; the receiver cannot stall, so it must take each result then.
// last marks the final result of an item; a list gives one result per entry,
// bottom to top (at most 16, the topmost ones), every other op but code seven gives one.
// Op code seven is ignored: no result, stack unchanged.
// Steps per item: push, op seven and every error found on the stack end in
// the decode step; pop reads the top, then emits; add/sub, multiply, divide
// and divide by zero read both operands first; multiply then forms three
// 32x32 partial products on one multiplier, divide one quotient bit per cycle
// in the divider, then the sign fix; a list does one stack read per entry.
// A result strobes in the cycle after the step that makes it; the last one
// of an item is taken at the same edge as the earliest next item.
// Reset clears the stack count and the sequencer; the stack memory itself is
// not cleared, since only entries below the count are ever read.
`include "rpn_stack_calculator_defines.svh"

module rpn_stack_calculator #(
	parameter int STACK_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         op,
	input  logic signed [63:0] value,
	output logic               strobe,
	output logic [2:0]         status,
	output logic signed [63:0] data,
	output logic               last
);

	// Control and status between sequencer and datapath
	rpn_pkg::cmd_t cmd;
	rpn_pkg::sts_t sts;

	// Result class decode for the checks below
	logic res_list;
	logic res_error;

	rpn_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	rpn_dpath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_op    (op),
		.in_value (value),
		.cmd      (cmd),
		.sts      (sts),
		.strobe   (strobe),
		.status   (status),
		.data     (data),
		.last     (last)
	);

	assign res_list  = (status == rpn_pkg::ST_LIST);
	assign res_error = (status == rpn_pkg::ST_EMPTY) || (status == rpn_pkg::ST_FEW) ||
		(status == rpn_pkg::ST_FULL) || (status == rpn_pkg::ST_DIVZERO);

	// Only list entries can be followed by more results of the same item.
	`RPN_ASSERT_NOW(a_single_last, strobe && !res_list, last, "non-list result without last")
	// Error results carry zero data.
	`RPN_ASSERT_NOW(a_err_zero, strobe && res_error, data == 64'd0, "error result with nonzero data")
	// A taken item keeps the block busy in the following cycle.
	`RPN_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
	// Never grow a full stack.
	`RPN_ASSERT_NOW(a_no_overfill, cmd.cnt_inc, !sts.full, "push onto a full stack")

endmodule

@@ test/rpn_stack_calculator_test.sv @@
module rpn_stack_calculator_test;

	localparam int DEPTH       = 16;
	localparam int ITEM_TARGET = 450;
	// Longest quiet stretch in a good run is a divide plus a sender gap; the
	// limit is kept well above that.
	localparam int IDLE_LIMIT  = 3000;
	localparam int TAIL_CYCLES = 150;

	// Op code seven has no name in the package; the block ignores it.
	localparam logic [2:0] OP_NONE = 3'd7;

	localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MOST_POS = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] MINUS_1  = 64'hffff_ffff_ffff_ffff;

	typedef struct {
		logic [2:0]  status;
		logic [63:0] data;
		logic        is_last;
	} calc_result_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [2:0]         op;
	logic signed [63:0] value;
	logic               strobe;
	logic [2:0]         status;
	logic signed [63:0] data;
	logic               last;

	// Shadow copy of the calculator state, updated as each item is taken.
	logic [63:0]  shadow_stack [DEPTH];
	int           shadow_depth;
	calc_result_t awaited_results [$];

	int fail_count;
	int items_sent;
	int burst_left;
	int idle_cycles;

	rpn_stack_calculator #(
		.STACK_DEPTH(DEPTH)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.op     (op),
		.value  (value),
		.strobe (strobe),
		.status (status),
		.data   (data),
		.last   (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		fail_count++;
		$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	// Signed division truncating toward zero, done on magnitudes so that
	// most-negative / -1 wraps instead of relying on simulator behavior.
	function automatic logic [63:0] trunc_div(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] ua;
		logic [63:0] ub;
		logic [63:0] q;
		ua = a[63] ? (64'd0 - a) : a;
		ub = b[63] ? (64'd0 - b) : b;
		q  = ua / ub;
		return (a[63] != b[63]) ? (64'd0 - q) : q;
	endfunction

	task automatic note_result(input logic [2:0] st, input logic [63:0] d, input logic lst);
		calc_result_t r;
		r.status  = st;
		r.data    = d;
		r.is_last = lst;
		awaited_results.insert(awaited_results.size(), r);
	endtask

	// Work out the results of one taken item and advance the shadow state.
	task automatic predict_item(input logic [2:0] item_op, input logic [63:0] item_value);
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] r;
		int first;
		case (item_op)
			rpn_pkg::OP_PUSH: begin
				if (shadow_depth >= DEPTH) begin
					note_result(rpn_pkg::ST_FULL, 64'd0, 1'b1);
				end else begin
					shadow_stack[shadow_depth] = item_value;
					shadow_depth++;
					note_result(rpn_pkg::ST_OK, 64'd0, 1'b1);
				end
			end
			rpn_pkg::OP_POP: begin
				if (shadow_depth == 0) begin
					note_result(rpn_pkg::ST_EMPTY, 64'd0, 1'b1);
				end else begin
					shadow_depth--;
					note_result(rpn_pkg::ST_POPPED, shadow_stack[shadow_depth], 1'b1);
				end
			end
			rpn_pkg::OP_LIST: begin
				if (shadow_depth == 0) begin
					note_result(rpn_pkg::ST_EMPTY, 64'd0, 1'b1);
				end else begin
					// only the topmost MAX_RESULTS entries fit in one listing
					first = (shadow_depth > rpn_pkg::MAX_RESULTS) ?
						shadow_depth - rpn_pkg::MAX_RESULTS : 0;
					for (int i = first; i < shadow_depth; i++) begin
						note_result(rpn_pkg::ST_LIST, shadow_stack[i],
							i == shadow_depth - 1);
					end
				end
			end
			rpn_pkg::OP_ADD, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV, rpn_pkg::OP_SUB: begin
				if (shadow_depth < 2) begin
					note_result(rpn_pkg::ST_FEW, 64'd0, 1'b1);
				end else begin
					b = shadow_stack[shadow_depth - 1];
					a = shadow_stack[shadow_depth - 2];
					if (item_op == rpn_pkg::OP_DIV && b == 64'd0) begin
						// stack is left as it was
						note_result(rpn_pkg::ST_DIVZERO, 64'd0, 1'b1);
					end else begin
						case (item_op)
							rpn_pkg::OP_ADD: r = a + b;
							rpn_pkg::OP_MUL: r = a * b;
							rpn_pkg::OP_DIV: r = trunc_div(a, b);
							default:         r = a - b;
						endcase
						shadow_depth--;
						shadow_stack[shadow_depth - 1] = r;
						note_result(rpn_pkg::ST_OK, r, 1'b1);
					end
				end
			end
			default: begin
				// ignored op: nothing comes back
			end
		endcase
	endtask

	// Drive one item at the falling edge and hold it until the block takes
	// it. The sender runs in bursts; a new burst may open with a gap.
	task automatic send_item(input logic [2:0] item_op, input logic [63:0] item_value);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			repeat (gap) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		start <= 1'b1;
		op    <= item_op;
		value <= item_value;
		do @(posedge clk); while (busy !== 1'b0);
		predict_item(item_op, item_value);
		if (item_op != OP_NONE) begin
			items_sent++;
		end
	endtask

	// Hold off the sender until every awaited result has been seen.
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (awaited_results.size() != 0) begin
			@(negedge clk);
		end
	endtask

	function automatic logic [63:0] rand_value();
		logic signed [63:0] s;
		case ($urandom_range(0, 9))
			0: return MOST_NEG;
			1: return MOST_POS;
			2: return 64'd0;
			3: return MINUS_1;
			4, 5: begin
				s = 64'($urandom_range(0, 200));
				return s - 64'sd100;
			end
			6: return {32'd0, $urandom};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [63:0] rand_divisor();
		case ($urandom_range(0, 5))
			0: return 64'd0;
			1: return MINUS_1;
			2: return 64'd1;
			default: return rand_value();
		endcase
	endfunction

	function automatic logic [2:0] rand_arith_op();
		case ($urandom_range(0, 3))
			0: return rpn_pkg::OP_ADD;
			1: return rpn_pkg::OP_MUL;
			2: return rpn_pkg::OP_DIV;
			default: return rpn_pkg::OP_SUB;
		endcase
	endfunction

	// Pop, list and add on an empty stack, the ignored code, and multiply on a one-deep stack.
	task automatic test_empty_stack();
		send_item(rpn_pkg::OP_POP, rand_value());
		send_item(rpn_pkg::OP_LIST, rand_value());
		send_item(rpn_pkg::OP_ADD, rand_value());
		send_item(OP_NONE, rand_value());
		send_item(rpn_pkg::OP_PUSH, 64'd5);
		send_item(rpn_pkg::OP_MUL, 64'd0);
		send_item(rpn_pkg::OP_POP, 64'd0);
		drain_results();
	endtask

	// Wraparound, most-negative / -1, divide by zero, truncation toward zero.
	task automatic test_arith_edges();
		send_item(rpn_pkg::OP_PUSH, MOST_POS);
		send_item(rpn_pkg::OP_PUSH, 64'd1);
		send_item(rpn_pkg::OP_ADD, 64'd0);
		send_item(rpn_pkg::OP_PUSH, MINUS_1);
		send_item(rpn_pkg::OP_DIV, 64'd0);
		send_item(rpn_pkg::OP_PUSH, 64'd0);
		send_item(rpn_pkg::OP_DIV, 64'd0);
		send_item(rpn_pkg::OP_POP, 64'd0);
		send_item(rpn_pkg::OP_ADD, 64'd0);
		send_item(rpn_pkg::OP_PUSH, -64'sd7);
		send_item(rpn_pkg::OP_PUSH, 64'sd2);
		send_item(rpn_pkg::OP_DIV, 64'd0);
		send_item(rpn_pkg::OP_MUL, 64'd0);
		send_item(rpn_pkg::OP_PUSH, 64'sd5);
		send_item(rpn_pkg::OP_SUB, 64'd0);
		send_item(rpn_pkg::OP_PUSH, 64'sd7);
		send_item(rpn_pkg::OP_PUSH, -64'sd2);
		send_item(rpn_pkg::OP_DIV, 64'd0);
		send_item(rpn_pkg::OP_LIST, 64'd0);
		send_item(rpn_pkg::OP_POP, 64'd0);
		send_item(rpn_pkg::OP_POP, 64'd0);
		send_item(rpn_pkg::OP_POP, 64'd0);
		drain_results();
	endtask

	// Fill to capacity, overflow once, list all of it, fold it down, empty it.
	task automatic test_full_stack();
		while (shadow_depth < DEPTH) begin
			send_item(rpn_pkg::OP_PUSH, rand_value());
		end
		send_item(rpn_pkg::OP_PUSH, rand_value());
		send_item(rpn_pkg::OP_LIST, rand_value());
		repeat ($urandom_range(0, DEPTH - 2)) begin
			send_item(rand_arith_op(), rand_value());
		end
		while (shadow_depth > 0) begin
			send_item(rpn_pkg::OP_POP, rand_value());
		end
		send_item(rpn_pkg::OP_POP, rand_value());
	endtask

	// Mostly well-formed expressions with random operands, plus fills,
	// divide checks, listings and a share of noise and broken sequences.
	task automatic test_random_sequences();
		int n;
		bit drained_once;
		drained_once = 1'b0;
		while (items_sent < ITEM_TARGET) begin
			if (!drained_once && items_sent >= ITEM_TARGET / 2) begin
				drain_results();
				drained_once = 1'b1;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					n = $urandom_range(2, 5);
					if (n > DEPTH - shadow_depth) begin
						n = DEPTH - shadow_depth;
					end
					repeat (n) begin
						send_item(rpn_pkg::OP_PUSH, rand_value());
					end
					if (shadow_depth >= 2) begin
						repeat ($urandom_range(1, shadow_depth - 1)) begin
							send_item(rand_arith_op(), rand_value());
						end
					end
					case ($urandom_range(0, 2))
						0: send_item(rpn_pkg::OP_POP, rand_value());
						1: send_item(rpn_pkg::OP_LIST, rand_value());
						default: begin
						end
					endcase
				end
				5: test_full_stack();
				6: begin
					// pop past the bottom
					while (shadow_depth > 0) begin
						send_item(($urandom_range(0, 3) == 0) ?
							rpn_pkg::OP_LIST : rpn_pkg::OP_POP, rand_value());
					end
					send_item(rpn_pkg::OP_POP, rand_value());
					send_item(rand_arith_op(), rand_value());
				end
				7: begin
					repeat ($urandom_range(3, 6)) begin
						send_item(3'($urandom_range(0, 7)), {$urandom, $urandom});
					end
				end
				8: begin
					if (shadow_depth <= DEPTH - 2) begin
						send_item(rpn_pkg::OP_PUSH, rand_value());
						send_item(rpn_pkg::OP_PUSH, rand_divisor());
					end
					send_item(rpn_pkg::OP_DIV, rand_value());
				end
				default: send_item(rpn_pkg::OP_LIST, rand_value());
			endcase
		end
	endtask

	// Result checker: the receiver cannot stall, so every strobe is a result.
	always @(posedge clk) begin
		calc_result_t exp_r;
		if (arst_n && strobe === 1'b1) begin
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result status=%0d data=%h last=%b",
					status, data, last));
			end else begin
				exp_r = awaited_results.pop_front();
				if (status !== exp_r.status) begin
					report_mismatch($sformatf("status %0d, wanted %0d", status, exp_r.status));
				end
				if (data !== exp_r.data) begin
					report_mismatch($sformatf("data %h, wanted %h", data, exp_r.data));
				end
				if (last !== exp_r.is_last) begin
					report_mismatch($sformatf("last %b, wanted %b", last, exp_r.is_last));
				end
			end
		end
	end

	// Watchdog: any accepted item or result restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe === 1'b1) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		op           = rpn_pkg::OP_PUSH;
		value        = '0;
		shadow_depth = 0;
		fail_count   = 0;
		items_sent   = 0;
		burst_left   = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_stack();
		test_arith_edges();
		test_full_stack();
		drain_results();
		test_random_sequences();

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
